/* rtl/gfa_pkg.sv */
`timescale 1ns / 1ps
package gfa_pkg;

   localparam int MAX_ORDER = 64;
   localparam int ORDER_W = 7;
   localparam int ELEM_W = 6;
   localparam int REM_W = 2 * ELEM_W;
   localparam int RED_STAGES = 3;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd2;
   localparam logic [ORDER_W-1:0] ORDER_CAP =
      (MAX_ORDER < 64) ? ORDER_W'(MAX_ORDER) : 7'd64;
   localparam logic [ORDER_W-1:0] ORDER_GF4 = 7'd4;
   localparam logic [ORDER_W-1:0] ORDER_GF8 = 7'd8;
   localparam logic [ORDER_W-1:0] ORDER_GF9 = 7'd9;

   // Each reduction stage performs two conditional subtractions of order << k,
   // starting at the shift given here and stepping down by one.
   localparam logic [2:0] RED_SHIFT [RED_STAGES] = '{3'd5, 3'd3, 3'd1};

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_MUL  = 2'd1,
      OP_NEG  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic             err;
   } stage_type;

   localparam logic [1:0] GF4_MUL [4][4] = '{
      '{2'd0, 2'd0, 2'd0, 2'd0},
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd2, 2'd3, 2'd1},
      '{2'd0, 2'd3, 2'd1, 2'd2}
   };

   localparam logic [2:0] GF8_MUL [8][8] = '{
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
      '{3'd0, 3'd2, 3'd4, 3'd6, 3'd3, 3'd1, 3'd7, 3'd5},
      '{3'd0, 3'd3, 3'd6, 3'd5, 3'd7, 3'd4, 3'd1, 3'd2},
      '{3'd0, 3'd4, 3'd3, 3'd7, 3'd6, 3'd2, 3'd5, 3'd1},
      '{3'd0, 3'd5, 3'd1, 3'd4, 3'd2, 3'd7, 3'd3, 3'd6},
      '{3'd0, 3'd6, 3'd7, 3'd1, 3'd5, 3'd3, 3'd2, 3'd4},
      '{3'd0, 3'd7, 3'd5, 3'd2, 3'd1, 3'd6, 3'd4, 3'd3}
   };

   localparam logic [3:0] GF9_MUL [16][9] = '{
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
      '{4'd0, 4'd2, 4'd1, 4'd6, 4'd8, 4'd7, 4'd3, 4'd5, 4'd4},
      '{4'd0, 4'd3, 4'd6, 4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7},
      '{4'd0, 4'd4, 4'd8, 4'd5, 4'd6, 4'd1, 4'd7, 4'd2, 4'd3},
      '{4'd0, 4'd5, 4'd7, 4'd8, 4'd1, 4'd3, 4'd4, 4'd6, 4'd2},
      '{4'd0, 4'd6, 4'd3, 4'd1, 4'd7, 4'd4, 4'd2, 4'd8, 4'd5},
      '{4'd0, 4'd7, 4'd5, 4'd4, 4'd2, 4'd6, 4'd8, 4'd3, 4'd1},
      '{4'd0, 4'd8, 4'd4, 4'd7, 4'd3, 4'd2, 4'd5, 4'd1, 4'd6},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
   };

   function automatic logic [1:0] gf9_hi(input logic [3:0] v);
      logic [1:0] h;
      if (v >= 4'd6) begin
         h = 2'd2;
      end else if (v >= 4'd3) begin
         h = 2'd1;
      end else begin
         h = 2'd0;
      end
      return h;
   endfunction

   function automatic logic [1:0] gf9_lo(input logic [3:0] v);
      logic [3:0] t;
      t = v - {2'b00, gf9_hi(v)} * 4'd3;
      return t[1:0];
   endfunction

   function automatic logic [1:0] add3(input logic [1:0] x, input logic [1:0] y);
      logic [2:0] s;
      logic [2:0] r;
      s = {1'b0, x} + {1'b0, y};
      r = (s >= 3'd3) ? (s - 3'd3) : s;
      return r[1:0];
   endfunction

   function automatic logic [1:0] neg3(input logic [1:0] x);
      logic [1:0] r;
      r = (x == 2'd0) ? 2'd0 : (2'd3 - x);
      return r;
   endfunction

   function automatic logic [3:0] gf9_pack(input logic [1:0] h, input logic [1:0] l);
      return {2'b00, h} * 4'd3 + {2'b00, l};
   endfunction

   function automatic logic [3:0] gf9_add(input logic [3:0] a, input logic [3:0] b);
      return gf9_pack(add3(gf9_hi(a), gf9_hi(b)), add3(gf9_lo(a), gf9_lo(b)));
   endfunction

   function automatic logic [3:0] gf9_neg(input logic [3:0] a);
      return gf9_pack(neg3(gf9_hi(a)), neg3(gf9_lo(a)));
   endfunction

endpackage

/* rtl/gfa_req_if.sv */
`timescale 1ns / 1ps
interface gfa_req_if
   import gfa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [ELEM_W-1:0] operand_a;
   logic [ELEM_W-1:0] operand_b;

   modport source (output valid, output op, output operand_a, output operand_b,
                   input ready);
   modport sink (input valid, input op, input operand_a, input operand_b,
                 output ready);
endinterface

/* rtl/gfa_rsp_if.sv */
`timescale 1ns / 1ps
interface gfa_rsp_if
   import gfa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] result;
   logic              range_error;

   modport source (output valid, output result, output range_error, input ready);
   modport sink (input valid, input result, input range_error, output ready);
endinterface

/* rtl/gfa_front.sv */
`timescale 1ns / 1ps
module gfa_front
   import gfa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ORDER_W-1:0] order,
   gfa_req_if.sink            req_chan,
   output logic               down_valid,
   output stage_type          down_data,
   input  logic               down_ready
);

   logic              valid_ff;
   stage_type         data_ff;
   stage_type         data_in;
   logic              up_ready;
   op_type            op;
   logic [ELEM_W-1:0] a;
   logic [ELEM_W-1:0] b;
   logic              bad;
   logic              xor_field;
   logic              nine;

   assign op = op_type'(req_chan.op);
   assign a = req_chan.operand_a;
   assign b = req_chan.operand_b;
   assign xor_field = (order == ORDER_GF4) || (order == ORDER_GF8);
   assign nine = (order == ORDER_GF9);

   always_comb begin
      bad = 1'b0;
      if (op != OP_NONE) begin
         bad = ({1'b0, a} >= order) || ((op != OP_NEG) && ({1'b0, b} >= order));
      end
   end

   always_comb begin
      data_in.err = bad;
      data_in.rem = '0;
      if (!bad) begin
         unique case (op)
            OP_ADD: begin
               if (xor_field) begin
                  data_in.rem = REM_W'(a ^ b);
               end else if (nine) begin
                  data_in.rem = REM_W'(gf9_add(a[3:0], b[3:0]));
               end else begin
                  data_in.rem = REM_W'({1'b0, a} + {1'b0, b});
               end
            end
            OP_MUL: begin
               if (order == ORDER_GF4) begin
                  data_in.rem = REM_W'(GF4_MUL[a[1:0]][b[1:0]]);
               end else if (order == ORDER_GF8) begin
                  data_in.rem = REM_W'(GF8_MUL[a[2:0]][b[2:0]]);
               end else if (nine) begin
                  data_in.rem = REM_W'(GF9_MUL[a[3:0]][b[3:0]]);
               end else begin
                  data_in.rem = REM_W'(a) * REM_W'(b);
               end
            end
            OP_NEG: begin
               if (xor_field) begin
                  data_in.rem = REM_W'(a);
               end else if (nine) begin
                  data_in.rem = REM_W'(gf9_neg(a[3:0]));
               end else if (a == '0) begin
                  data_in.rem = '0;
               end else begin
                  data_in.rem = REM_W'(order - {1'b0, a});
               end
            end
            OP_NONE: begin
               data_in.rem = '0;
            end
            default: begin
               data_in.rem = '0;
            end
         endcase
      end
   end

   assign up_ready = !valid_ff || down_ready;
   assign req_chan.ready = up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

/* rtl/gfa_reduce.sv */
`timescale 1ns / 1ps
module gfa_reduce
   import gfa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ORDER_W-1:0] order,
   input  logic [2:0]         shift_hi,
   input  logic               up_valid,
   input  stage_type          up_data,
   output logic               up_ready,
   output logic               down_valid,
   output stage_type          down_data,
   input  logic               down_ready
);

   logic             valid_ff;
   stage_type        data_ff;
   stage_type        data_in;
   logic [REM_W:0]   sub_hi;
   logic [REM_W:0]   sub_lo;
   logic [REM_W:0]   rem_mid;
   logic [REM_W:0]   rem_end;

   assign sub_hi = (REM_W + 1)'(order) << shift_hi;
   assign sub_lo = (REM_W + 1)'(order) << (shift_hi - 3'd1);

   always_comb begin
      rem_mid = {1'b0, up_data.rem};
      if (rem_mid >= sub_hi) begin
         rem_mid = rem_mid - sub_hi;
      end
      rem_end = rem_mid;
      if (rem_end >= sub_lo) begin
         rem_end = rem_end - sub_lo;
      end
      data_in.err = up_data.err;
      data_in.rem = rem_end[REM_W-1:0];
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

/* rtl/small_galois_field_alu.sv */
`timescale 1ns / 1ps
// Channel    Direction  Handshake     Payload
// req_chan   in         valid/ready   op, operand_a, operand_b
// rsp_chan   out        valid/ready   result, range_error
// csr        in         csr_wr_en     csr_wr_data (field order)
//
// One transfer is accepted per cycle unless a stalled result has filled the pipeline;
// each result is registered in the front stage for operand checks, tables and the
// product, then in each stage of the modular reduction, two conditional subtractions each.
// Reset is synchronous and sets the field order to 2 and empties the pipeline.
// A stalled result holds every stage that is full; empty stages still fill.
module small_galois_field_alu
   import gfa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   gfa_req_if.sink            req_chan,
   gfa_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [ORDER_W-1:0] csr_wr_data
);

   logic [ORDER_W-1:0] field_order_ff;
   logic [ORDER_W-1:0] order;
   logic               link_valid [RED_STAGES+1];
   stage_type          link_data [RED_STAGES+1];
   logic               link_ready [RED_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         field_order_ff <= ORDER_RESET;
      end else if (csr_wr_en) begin
         field_order_ff <= csr_wr_data;
      end
   end

   assign order = (field_order_ff > ORDER_CAP) ? ORDER_CAP : field_order_ff;

   gfa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .order      (order),
      .req_chan   (req_chan),
      .down_valid (link_valid[0]),
      .down_data  (link_data[0]),
      .down_ready (link_ready[0])
   );

   for (genvar s = 0; s < RED_STAGES; s++) begin : g_reduce
      gfa_reduce u_reduce (
         .clock      (clock),
         .reset      (reset),
         .order      (order),
         .shift_hi   (RED_SHIFT[s]),
         .up_valid   (link_valid[s]),
         .up_data    (link_data[s]),
         .up_ready   (link_ready[s]),
         .down_valid (link_valid[s+1]),
         .down_data  (link_data[s+1]),
         .down_ready (link_ready[s+1])
      );
   end

   assign link_ready[RED_STAGES] = rsp_chan.ready;
   assign rsp_chan.valid = link_valid[RED_STAGES];
   assign rsp_chan.result = link_data[RED_STAGES].rem[ELEM_W-1:0];
   assign rsp_chan.range_error = link_data[RED_STAGES].err;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.range_error |-> rsp_chan.result == '0)
      else $error("Flagged result is not zero.");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.range_error && order != '0
         |-> {1'b0, rsp_chan.result} < order)
      else $error("Result is not below the field order.");

   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> link_data[RED_STAGES].rem[REM_W-1:ELEM_W] == '0)
      else $error("Reduction left high remainder bits.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("Result valid right after reset.");
`endif

endmodule
